// ===== rtl/ttuv_pkg.sv =====
package ttuv_pkg;

    // Field and datapath widths
    localparam int COORD_W   = 32;                // one Q-format coordinate
    localparam int DIFF_W    = COORD_W + 1;       // exact edge / uv delta
    localparam int PROD_W    = 2 * DIFF_W;        // exact signed product
    localparam int MAG_W     = PROD_W;            // magnitude of a product difference
    localparam int QUO_W     = COORD_W + 1;       // quotient bits kept by the divider
    localparam int S_TDATA_W = 5 * COORD_W;       // pos_x, pos_y, pos_z, tex_u, tex_v
    localparam int M_TDATA_W = 3 * COORD_W;       // tangent_x, tangent_y, tangent_z

    // Saturation limits of a tangent component
    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // One finished triangle: uv deltas and the two position edges per axis
    typedef struct packed {
        logic signed [DIFF_W-1:0] du1;
        logic signed [DIFF_W-1:0] dv1;
        logic signed [DIFF_W-1:0] du2;
        logic signed [DIFF_W-1:0] dv2;
        logic [2:0][DIFF_W-1:0]   e1;
        logic [2:0][DIFF_W-1:0]   e2;
    } job_t;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ===== rtl/ttuv_front.sv =====
module ttuv_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ttuv_pkg::S_TDATA_W-1:0] s_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
    input  ttuv_pkg::fifo_stat_t         stat,
    output logic                         push,
    output ttuv_pkg::job_t               push_job
);

    typedef enum logic [2:0] {
        C0 = 3'b001,
        C1 = 3'b010,
        C2 = 3'b100
    } corner_t;

    localparam int CW = ttuv_pkg::COORD_W;

    corner_t phase_reg, phase_next;
    logic [4:0][CW-1:0] v0_reg, v1_reg;
    logic [4:0][CW-1:0] cur;
    logic accept;

    assign cur = s_tdata;

    // Only the closing corner needs room in the queue
    assign s_tready = (phase_reg != C2) || !stat.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (phase_reg == C2);

    // Sign-extended differences against the first corner
    function automatic logic signed [ttuv_pkg::DIFF_W-1:0] sdiff(
        input logic [CW-1:0] a,
        input logic [CW-1:0] b
    );
        sdiff = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    always_comb begin
        push_job.du1 = sdiff(v1_reg[3], v0_reg[3]);
        push_job.dv1 = sdiff(v1_reg[4], v0_reg[4]);
        push_job.du2 = sdiff(cur[3], v0_reg[3]);
        push_job.dv2 = sdiff(cur[4], v0_reg[4]);
        for (int c = 0; c < 3; c++) begin
            push_job.e1[c] = sdiff(v1_reg[c], v0_reg[c]);
            push_job.e2[c] = sdiff(cur[c], v0_reg[c]);
        end
    end

    // Corner sequencing
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                C0:      phase_next = C1;
                C1:      phase_next = C2;
                C2:      phase_next = C0;
                default: phase_next = C0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= C0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Held corners, payload only
    always_ff @(posedge aclk) begin
        if (accept && phase_reg == C0) begin
            v0_reg <= cur;
        end
        if (accept && phase_reg == C1) begin
            v1_reg <= cur;
        end
    end

endmodule

// ===== rtl/ttuv_fifo.sv =====
module ttuv_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ttuv_pkg::job_t       push_job,
    input  logic                 pop,
    output ttuv_pkg::job_t       pop_job,
    output ttuv_pkg::fifo_stat_t stat
);

    ttuv_pkg::job_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign pop_job    = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/ttuv_back.sv =====
module ttuv_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ttuv_pkg::fifo_stat_t           stat,
    input  ttuv_pkg::job_t                 pop_job,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ttuv_pkg::M_TDATA_W-1:0] m_tdata,  // tangent_x, tangent_y, tangent_z
    output logic [0:0]                     m_tuser   // degenerate
);

    localparam int CW    = ttuv_pkg::COORD_W;
    localparam int DW_   = ttuv_pkg::DIFF_W;
    localparam int PW    = ttuv_pkg::PROD_W;
    localparam int MW    = ttuv_pkg::MAG_W;
    localparam int QW    = ttuv_pkg::QUO_W;
    localparam int DIVD_W = MW + FRAC_BITS;   // scaled dividend
    localparam int HI_W  = DIVD_W - QW;       // part above the quotient window
    localparam int CNT_W = $clog2(QW);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DET0   = 12'b000000000010,
        S_DET1   = 12'b000000000100,
        S_DET2   = 12'b000000001000,
        S_DETCHK = 12'b000000010000,
        S_NUM0   = 12'b000000100000,
        S_NUM1   = 12'b000001000000,
        S_NUM2   = 12'b000010000000,
        S_ABS    = 12'b000100000000,
        S_PRE    = 12'b001000000000,
        S_DIV    = 12'b010000000000,
        S_RND    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_pend_reg, out_pend_next;

    ttuv_pkg::job_t          job_reg;
    logic signed [PW-1:0]    prod_reg, acc_reg;
    logic signed [PW:0]      diff_reg;
    logic [MW-1:0]           den_mag_reg, num_mag_reg, rem_reg;
    logic                    den_neg_reg, neg_reg;
    logic [QW-1:0]           lo_reg, q_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [1:0]              comp_reg;
    logic [2:0][CW-1:0]      res_reg;
    logic                    deg_reg;
    logic                    m_tvalid_reg;
    logic [ttuv_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [0:0]              m_tuser_reg;

    // Shared multiplier
    logic signed [DW_-1:0] mul_a, mul_b;
    logic signed [PW-1:0]  mul_p;

    always_comb begin
        case (state_reg)
            S_DET1: begin
                mul_a = job_reg.dv1;
                mul_b = job_reg.du2;
            end
            S_NUM0: begin
                mul_a = $signed(job_reg.e1[comp_reg]);
                mul_b = job_reg.dv2;
            end
            S_NUM1: begin
                mul_a = $signed(job_reg.e2[comp_reg]);
                mul_b = job_reg.dv1;
            end
            default: begin
                mul_a = job_reg.du1;
                mul_b = job_reg.dv2;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Datapath helpers
    logic [PW:0]        diff_abs;
    logic [DIVD_W-1:0]  dividend;
    logic [HI_W-1:0]    div_hi;
    logic               pre_sat;
    logic [MW:0]        trial;
    logic               trial_ge;
    logic [MW:0]        trial_sub;
    logic               rnd_up;
    logic [QW:0]        q_rnd;
    logic [CW-1:0]      rnd_val;
    logic               out_free;
    logic               last_comp;

    assign diff_abs  = diff_reg[PW] ? (~diff_reg + 1'b1) : diff_reg;
    assign dividend  = {num_mag_reg, {FRAC_BITS{1'b0}}};
    assign div_hi    = dividend[DIVD_W-1:QW];
    // quotient of 2^QW or more saturates for either sign
    assign pre_sat   = MW'(div_hi) >= den_mag_reg;
    assign trial     = {rem_reg, lo_reg[QW-1]};
    assign trial_ge  = trial >= {1'b0, den_mag_reg};
    assign trial_sub = trial - {1'b0, den_mag_reg};
    assign rnd_up    = {rem_reg, 1'b0} >= {1'b0, den_mag_reg};
    assign q_rnd     = {1'b0, q_reg} + (QW+1)'(rnd_up);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_comp = (comp_reg == 2'd2);

    // Round half away from zero, then saturate
    always_comb begin
        if (neg_reg) begin
            if (q_rnd > (QW+1)'({1'b1, {(CW-1){1'b0}}})) begin
                rnd_val = ttuv_pkg::SAT_MIN;
            end else begin
                rnd_val = CW'(~q_rnd[CW-1:0] + 1'b1);
            end
        end else begin
            if (q_rnd > (QW+1)'(ttuv_pkg::SAT_MAX)) begin
                rnd_val = ttuv_pkg::SAT_MAX;
            end else begin
                rnd_val = q_rnd[CW-1:0];
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        out_pend_next = out_pend_reg;
        pop           = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (out_pend_reg) begin
                    if (out_free) begin
                        out_pend_next = 1'b0;
                    end
                end else if (!stat.empty) begin
                    pop        = 1'b1;
                    state_next = S_DET0;
                end
            end
            S_DET0:   state_next = S_DET1;
            S_DET1:   state_next = S_DET2;
            S_DET2:   state_next = S_DETCHK;
            S_DETCHK: begin
                if (diff_reg == '0) begin
                    out_pend_next = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    state_next = S_NUM0;
                end
            end
            S_NUM0:   state_next = S_NUM1;
            S_NUM1:   state_next = S_NUM2;
            S_NUM2:   state_next = S_ABS;
            S_ABS:    state_next = S_PRE;
            S_PRE: begin
                if (!pre_sat) begin
                    state_next = S_DIV;
                end else if (last_comp) begin
                    out_pend_next = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    state_next = S_NUM0;
                end
            end
            S_DIV: begin
                if (cnt_reg == CNT_W'(QW - 1)) begin
                    state_next = S_RND;
                end
            end
            S_RND: begin
                if (last_comp) begin
                    out_pend_next = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    state_next = S_NUM0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            out_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            out_pend_reg <= out_pend_next;
            if (state_reg == S_IDLE && out_pend_reg && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                job_reg <= pop_job;
                if (out_pend_reg && out_free) begin
                    m_tdata_reg <= res_reg;
                    m_tuser_reg <= deg_reg;
                end
            end
            S_DET0: prod_reg <= mul_p;
            S_DET1: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            S_DET2: diff_reg <= {acc_reg[PW-1], acc_reg} - {prod_reg[PW-1], prod_reg};
            S_DETCHK: begin
                den_neg_reg <= diff_reg[PW];
                den_mag_reg <= diff_abs[MW-1:0];
                comp_reg    <= 2'd0;
                deg_reg     <= (diff_reg == '0);
                res_reg     <= '0;
            end
            S_NUM0: prod_reg <= mul_p;
            S_NUM1: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            S_NUM2: diff_reg <= {acc_reg[PW-1], acc_reg} - {prod_reg[PW-1], prod_reg};
            S_ABS: begin
                neg_reg     <= diff_reg[PW] ^ den_neg_reg;
                num_mag_reg <= diff_abs[MW-1:0];
            end
            S_PRE: begin
                if (pre_sat) begin
                    res_reg[comp_reg] <= neg_reg ? ttuv_pkg::SAT_MIN : ttuv_pkg::SAT_MAX;
                    comp_reg          <= comp_reg + 2'd1;
                end else begin
                    rem_reg <= MW'(div_hi);
                    lo_reg  <= dividend[QW-1:0];
                    q_reg   <= '0;
                    cnt_reg <= '0;
                end
            end
            S_DIV: begin
                rem_reg <= trial_ge ? trial_sub[MW-1:0] : trial[MW-1:0];
                q_reg   <= {q_reg[QW-2:0], trial_ge};
                lo_reg  <= {lo_reg[QW-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_RND: begin
                res_reg[comp_reg] <= rnd_val;
                comp_reg          <= comp_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/triangle_tangent_from_uv.sv =====
// A triangle's result follows its third vertex beat: determinant setup, then, unless degenerate,
// per component the products and one 33-step restoring divider shared by x, y, z.
// The back end takes one triangle at a time and finishes it before popping the next.
// A two-entry triangle queue lets vertices keep arriving while the divider works.
// Reset: aresetn is synchronous, active low; it clears the corner count, queue and
// output valid. Held vertex data is not reset.
module triangle_tangent_from_uv #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ttuv_pkg::S_TDATA_W-1:0] s_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ttuv_pkg::M_TDATA_W-1:0] m_tdata,  // tangent_x, tangent_y, tangent_z
    output logic [0:0]                     m_tuser   // degenerate
);

    ttuv_pkg::fifo_stat_t stat;
    ttuv_pkg::job_t       push_job, pop_job;
    logic                 push, pop;

    // Vertex collection and edge setup
    ttuv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .stat     (stat),
        .push     (push),
        .push_job (push_job)
    );

    // Triangle queue
    ttuv_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (stat)
    );

    // Products, divider and output register
    ttuv_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/ttuv_checker.sv =====
module ttuv_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ttuv_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);

    logic [1:0] corner_reg;
    logic [2:0] pending_reg;
    logic       s_beat, m_beat, tri_done;

    assign s_beat   = s_tvalid && s_tready;
    assign m_beat   = m_tvalid && m_tready;
    assign tri_done = s_beat && (corner_reg == 2'd2);

    // Count triangles closed at the input and not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg  <= 2'd0;
            pending_reg <= 3'd0;
        end else begin
            if (s_beat) begin
                corner_reg <= (corner_reg == 2'd2) ? 2'd0 : corner_reg + 2'd1;
            end
            if (tri_done && !m_beat) begin
                pending_reg <= pending_reg + 3'd1;
            end else if (m_beat && !tri_done) begin
                pending_reg <= pending_reg - 3'd1;
            end
        end
    end

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Degenerate triangles carry a zero tangent
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("degenerate result with nonzero tangent");

    // No result without a closed triangle
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat |-> pending_reg != 3'd0)
        else $error("result beat without a triangle");

    // Queue, divider and output register bound the backlog
    a_backlog: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd4)
        else $error("more triangles in flight than storage allows");

endmodule

bind triangle_tangent_from_uv ttuv_checker u_ttuv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/tb_triangle_tangent_from_uv.sv =====
`timescale 1ns / 1ps

module tb_triangle_tangent_from_uv;

    localparam int FRAC_BITS  = 16;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int IDLE_LIMIT = 20000;    // cycles with no beat on either side
    localparam int HOLD_LONG  = 4000;     // one long receiver hold-off
    localparam int DRAIN_WAIT = 300;      // > block latency after the last result
    localparam int RAND_TRIS  = 542;      // random triangles, three beats each
    localparam int MAX_LINES  = 30;       // mismatch lines printed before going quiet

    localparam logic signed [31:0] CMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] CMIN = 32'sh80000000;

    // One vertex; packed so that pos_x sits in the low bits of s_tdata
    typedef struct packed {
        logic signed [31:0] v;
        logic signed [31:0] u;
        logic signed [31:0] pz;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } vertex_t;

    typedef struct packed {
        logic        degen;
        logic [31:0] tz;
        logic [31:0] ty;
        logic [31:0] tx;
    } tangent_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ttuv_pkg::S_TDATA_W-1:0] s_tdata  = '0;   // pos_x, pos_y, pos_z, tex_u, tex_v
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ttuv_pkg::M_TDATA_W-1:0] m_tdata;          // tangent_x, tangent_y, tangent_z
    logic [0:0]                     m_tuser;          // degenerate

    vertex_t  vertex_pending[$];
    tangent_t tangent_expected[$];
    vertex_t  corner_store[2];
    logic [1:0] corner_idx;
    vertex_t  vertex_on_bus;
    int       beats_sent;
    int       total_beats;
    int       tangents_seen;
    int       mismatches;
    int       send_gap;
    int       recv_hold;
    bit       long_hold_done;
    int       idle_cycles;

    triangle_tangent_from_uv #(.FRAC_BITS(FRAC_BITS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // (num << FRAC_BITS) / den, round half away from zero, saturate to 32 bits
    function automatic logic [31:0] scaled_quotient(logic signed [127:0] num,
                                                    logic signed [127:0] den);
        logic         neg;
        logic [127:0] n, d, q, r;
        neg = num[127] ^ den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        n = n << FRAC_BITS;
        q = n / d;
        r = n % d;
        if ((r << 1) >= d) q = q + 1;
        if (neg) begin
            if (q > 128'h80000000) return ttuv_pkg::SAT_MIN;
            return -q[31:0];
        end
        if (q > 128'h7FFFFFFF) return ttuv_pkg::SAT_MAX;
        return q[31:0];
    endfunction

    function automatic tangent_t triangle_tangent(vertex_t a, vertex_t b, vertex_t c);
        logic signed [127:0] du1, dv1, du2, dv2, det, e1, e2;
        logic signed [31:0]  pa [3];
        logic signed [31:0]  pb [3];
        logic signed [31:0]  pc [3];
        logic [31:0]         comp [3];
        tangent_t            t;
        du1 = b.u - a.u;
        dv1 = b.v - a.v;
        du2 = c.u - a.u;
        dv2 = c.v - a.v;
        det = du1 * dv2 - dv1 * du2;
        t = '0;
        if (det == 0) begin
            t.degen = 1'b1;
            return t;
        end
        pa = '{a.px, a.py, a.pz};
        pb = '{b.px, b.py, b.pz};
        pc = '{c.px, c.py, c.pz};
        for (int i = 0; i < 3; i++) begin
            e1 = pb[i] - pa[i];
            e2 = pc[i] - pa[i];
            comp[i] = scaled_quotient(e1 * dv2 - e2 * dv1, det);
        end
        t.tx = comp[0];
        t.ty = comp[1];
        t.tz = comp[2];
        return t;
    endfunction

    // Corner bookkeeping: the third corner of each triangle yields one tangent
    task automatic take_vertex(vertex_t vx);
        if (corner_idx < 2'd2) begin
            corner_store[corner_idx[0]] = vx;
            corner_idx = corner_idx + 2'd1;
        end else begin
            tangent_expected.push_back(triangle_tangent(corner_store[0], corner_store[1], vx));
            corner_idx = 2'd0;
        end
    endtask

    task automatic log_mismatch(string msg);
        if (mismatches < MAX_LINES) $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("tangent %0d %s got %h want %h",
                                   tangents_seen, name, got, want));
    endtask

    function automatic vertex_t vtx(logic signed [31:0] px, logic signed [31:0] py,
                                    logic signed [31:0] pz, logic signed [31:0] u,
                                    logic signed [31:0] v);
        vertex_t r;
        r.px = px;
        r.py = py;
        r.pz = pz;
        r.u  = u;
        r.v  = v;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_scaled();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    function automatic logic signed [31:0] rand_mesh_pos();
        return $signed($urandom_range(0, 200 * ONE)) - 100 * ONE;
    endfunction

    task automatic push_random_triangle();
        int                 mode, k;
        logic signed [31:0] u0, v0, u1, v1;
        mode = $urandom_range(0, 99);
        if (mode < 40) begin
            // typical mesh: modest positions, uv inside the unit square
            repeat (3)
                vertex_pending.push_back(vtx(rand_mesh_pos(), rand_mesh_pos(),
                                             rand_mesh_pos(), $urandom_range(0, ONE),
                                             $urandom_range(0, ONE)));
        end else if (mode < 58) begin
            repeat (3)
                vertex_pending.push_back(vtx($urandom, $urandom, $urandom,
                                             $urandom, $urandom));
        end else if (mode < 70) begin
            // collinear uv: third corner on the line through the first two
            u0 = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            v0 = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            u1 = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            v1 = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            k  = $urandom_range(0, 4) - 2;
            vertex_pending.push_back(vtx($urandom, $urandom, $urandom, u0, v0));
            vertex_pending.push_back(vtx($urandom, $urandom, $urandom, u1, v1));
            vertex_pending.push_back(vtx($urandom, $urandom, $urandom,
                                         u0 + k * (u1 - u0), v0 + k * (v1 - v0)));
        end else if (mode < 85) begin
            // tiny uv determinant, big edges: saturation territory
            u0 = $urandom;
            v0 = $urandom;
            vertex_pending.push_back(vtx($urandom, $urandom, $urandom, u0, v0));
            repeat (2)
                vertex_pending.push_back(vtx($urandom, $urandom, $urandom,
                                             u0 + $urandom_range(0, 6) - 3,
                                             v0 + $urandom_range(0, 6) - 3));
        end else begin
            repeat (3)
                vertex_pending.push_back(vtx(rand_scaled(), rand_scaled(), rand_scaled(),
                                             rand_scaled(), rand_scaled()));
        end
    endtask

    // Sender: offers queued vertices with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            corner_idx = 2'd0;
            send_gap   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_vertex(vertex_on_bus);
                beats_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (vertex_pending.size() != 0) begin
                    vertex_on_bus = vertex_pending.pop_front();
                    s_tdata  <= vertex_on_bus;
                    s_tvalid <= 1'b1;
                    // calm stretches with back-to-back beats
                    send_gap = ((beats_sent % 300) < 60) ? 0 : pick_idle();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each tangent beat, stalls at random, one long hold-off
    always @(posedge aclk) begin
        tangent_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.tx    = m_tdata[31:0];
                got.ty    = m_tdata[63:32];
                got.tz    = m_tdata[95:64];
                got.degen = m_tuser[0];
                if (tangent_expected.size() == 0) begin
                    log_mismatch("tangent beat with no triangle outstanding");
                end else begin
                    want = tangent_expected.pop_front();
                    check_field("tangent_x", got.tx, want.tx);
                    check_field("tangent_y", got.ty, want.ty);
                    check_field("tangent_z", got.tz, want.tz);
                    check_field("degenerate", 32'(got.degen), 32'(want.degen));
                end
                tangents_seen++;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && tangents_seen >= 40) begin
                // let the block fill up and push back on the sender
                long_hold_done = 1'b1;
                recv_hold = HOLD_LONG;
                m_tready <= 1'b0;
            end else if ((tangents_seen % 100) < 20) begin
                m_tready <= 1'b1;
            end else begin
                recv_hold = pick_idle();
                m_tready <= (recv_hold == 0);
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        // basic right triangle in uv: tangent along +x
        vertex_pending.push_back(vtx(0, 0, 0, 0, 0));
        vertex_pending.push_back(vtx(ONE, 0, 0, ONE, 0));
        vertex_pending.push_back(vtx(0, ONE, 0, 0, ONE));
        // all uv equal: degenerate
        vertex_pending.push_back(vtx(CMAX, CMIN, 3, 5, 7));
        vertex_pending.push_back(vtx(-9, 11, CMAX, 5, 7));
        vertex_pending.push_back(vtx(CMIN, 0, -1, 5, 7));
        // collinear uv: degenerate
        vertex_pending.push_back(vtx(1, 2, 3, 0, 0));
        vertex_pending.push_back(vtx(4, 5, 6, ONE, ONE));
        vertex_pending.push_back(vtx(7, 8, 9, 2 * ONE, 2 * ONE));
        // unit determinant with extreme edges: saturation both ways
        vertex_pending.push_back(vtx(0, 0, 0, 0, 0));
        vertex_pending.push_back(vtx(CMAX, CMIN, ONE, 1, 0));
        vertex_pending.push_back(vtx(CMIN, CMAX, 0, 0, 1));
        vertex_pending.push_back(vtx(CMAX, CMIN, 0, 0, 0));
        vertex_pending.push_back(vtx(0, 0, 0, 0, 1));
        vertex_pending.push_back(vtx(CMIN, CMAX, -1, -1, 0));
        // largest uv determinant
        vertex_pending.push_back(vtx(CMIN, CMAX, 0, CMIN, CMIN));
        vertex_pending.push_back(vtx(CMAX, CMIN, CMAX, CMAX, CMIN));
        vertex_pending.push_back(vtx(CMAX, CMAX, CMIN, CMIN, CMAX));
        // exact halves: rounding away from zero, positive determinant
        vertex_pending.push_back(vtx(0, 0, 0, 0, 0));
        vertex_pending.push_back(vtx(1, -1, 3, 1 << 17, 0));
        vertex_pending.push_back(vtx(7, -7, 0, 0, 1));
        // exact halves with a negative determinant
        vertex_pending.push_back(vtx(0, 0, 0, 0, 0));
        vertex_pending.push_back(vtx(1, -1, -3, -(1 << 17), 0));
        vertex_pending.push_back(vtx(-1, -1, -1, 0, 1));
        for (int i = 0; i < RAND_TRIS; i++) push_random_triangle();
        total_beats = vertex_pending.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (beats_sent < total_beats) @(negedge aclk);
        while (tangent_expected.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
